// ===== rtl/indented_text_line_lexer_top_defines.svh =====
// Assertion macros for the indented text line lexer.
`ifndef INDENTED_TEXT_LINE_LEXER_TOP_DEFINES_SVH
`define INDENTED_TEXT_LINE_LEXER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ITLL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itll assertion failed");
`define ITLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itll assertion failed");
`else
`define ITLL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ITLL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/itll_pkg.sv =====
`timescale 1ns / 1ps

package itll_pkg;

   localparam int LEVEL_DEFAULT = 255;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_CHAR,
      KIND_EOL,
      KIND_ERR
   } itll_kind_type;

   typedef enum logic [1:0] {
      FIELD_NAME,
      FIELD_TYPE,
      FIELD_VALUE
   } itll_field_type;

   typedef enum logic [1:0] {
      ERR_LEVEL_JUMP,
      ERR_LEADING_SPACE,
      ERR_TYPE_SEP,
      ERR_REPEAT_ASSIGN
   } itll_err_type;

   typedef struct packed {
      itll_kind_type  kind;
      itll_field_type target_field;
      logic [7:0]     character;
      logic [7:0]     line_level;
      logic           bare_line;
      logic           append_nul;
      itll_err_type   error_code;
   } itll_rsp_type;

endpackage

// ===== rtl/itll_core.sv =====
`timescale 1ns / 1ps

module itll_core import itll_pkg::*; #(
   parameter int MAX_LEVEL = LEVEL_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         doc_start,
   input  logic [7:0]   byte_in,
   output itll_rsp_type rsp
);

   localparam int IW = $clog2(MAX_LEVEL + 1);
   localparam int MW = IW + 1;

   typedef enum logic [1:0] {
      PH_INDENT,
      PH_CONTENT,
      PH_ERROR
   } phase_type;

   phase_type      phase_ff, phase_in, cur_phase;
   logic [IW-1:0]  indent_ff, indent_in, cur_indent;
   logic [MW-1:0]  max_ff, max_in, cur_max;
   logic           started_ff, started_in, cur_started;
   logic           esc_ff, esc_in, cur_esc;
   itll_field_type field_ff, field_in, cur_field;
   logic           seen_type_ff, seen_type_in, cur_seen_type;
   logic           seen_assign_ff, seen_assign_in, cur_seen_assign;

   logic [IW+7:0]  lvl_ext;
   logic [7:0]     lvl;
   logic           level_bad;
   logic           do_content;
   logic           do_eol;
   logic           do_err;
   itll_err_type   err_code;

   always_comb begin
      cur_phase       = doc_start ? PH_INDENT  : phase_ff;
      cur_indent      = doc_start ? '0         : indent_ff;
      cur_max         = doc_start ? '0         : max_ff;
      cur_started     = doc_start ? 1'b0       : started_ff;
      cur_esc         = doc_start ? 1'b0       : esc_ff;
      cur_field       = doc_start ? FIELD_NAME : field_ff;
      cur_seen_type   = doc_start ? 1'b0       : seen_type_ff;
      cur_seen_assign = doc_start ? 1'b0       : seen_assign_ff;

      lvl_ext   = {8'd0, cur_indent};
      lvl       = lvl_ext[7:0];
      level_bad = {1'b0, cur_indent} > cur_max;

      phase_in       = cur_phase;
      indent_in      = cur_indent;
      max_in         = cur_max;
      started_in     = cur_started;
      esc_in         = cur_esc;
      field_in       = cur_field;
      seen_type_in   = cur_seen_type;
      seen_assign_in = cur_seen_assign;

      rsp        = '0;
      do_content = 1'b0;
      do_eol     = 1'b0;
      do_err     = 1'b0;
      err_code   = ERR_LEVEL_JUMP;

      unique case (cur_phase)
         PH_CONTENT: begin
            if (byte_in == CH_NEWLINE) begin
               do_eol = 1'b1;
            end else begin
               do_content = 1'b1;
            end
         end
         PH_INDENT: begin
            if (byte_in == CH_NEWLINE) begin
               if (cur_started) begin
                  if (level_bad) begin
                     do_err = 1'b1;
                  end else begin
                     max_in = {1'b0, cur_indent} + MW'(1);
                     do_eol = 1'b1;
                  end
               end
            end else if (byte_in == CH_TAB) begin
               started_in = 1'b1;
               if (cur_indent >= IW'(MAX_LEVEL)) begin
                  do_err = 1'b1;
               end else begin
                  indent_in = cur_indent + IW'(1);
               end
            end else begin
               started_in = 1'b1;
               if (level_bad) begin
                  do_err = 1'b1;
               end else begin
                  max_in = {1'b0, cur_indent} + MW'(1);
                  if (byte_in == CH_SPACE) begin
                     do_err   = 1'b1;
                     err_code = ERR_LEADING_SPACE;
                  end else begin
                     phase_in   = PH_CONTENT;
                     do_content = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (do_content) begin
         if (cur_esc) begin
            esc_in           = 1'b0;
            rsp.kind         = KIND_CHAR;
            rsp.target_field = cur_field;
            rsp.line_level   = lvl;
            if (byte_in == CH_PIPE) begin
               rsp.character = CH_NEWLINE;
            end else if (byte_in == CH_GREATER) begin
               rsp.character = CH_TAB;
            end else begin
               rsp.character = byte_in;
            end
         end else if (byte_in == CH_QUOTE) begin
            esc_in = 1'b1;
         end else if (byte_in == CH_CARET) begin
            if (cur_seen_type || cur_seen_assign) begin
               do_err   = 1'b1;
               err_code = ERR_TYPE_SEP;
            end else begin
               field_in     = FIELD_TYPE;
               seen_type_in = 1'b1;
            end
         end else if (byte_in == CH_EQUALS) begin
            if (cur_seen_assign) begin
               do_err   = 1'b1;
               err_code = ERR_REPEAT_ASSIGN;
            end else begin
               field_in       = FIELD_VALUE;
               seen_assign_in = 1'b1;
            end
         end else begin
            rsp.kind         = KIND_CHAR;
            rsp.target_field = cur_field;
            rsp.character    = byte_in;
            rsp.line_level   = lvl;
         end
      end

      if (do_err) begin
         phase_in       = PH_ERROR;
         rsp            = '0;
         rsp.kind       = KIND_ERR;
         rsp.line_level = lvl;
         rsp.error_code = err_code;
      end else if (do_eol) begin
         rsp.kind         = KIND_EOL;
         rsp.target_field = cur_field;
         rsp.line_level   = lvl;
         rsp.bare_line    = !cur_seen_type && !cur_seen_assign;
         rsp.append_nul   = cur_esc;
         phase_in         = PH_INDENT;
         indent_in        = '0;
         started_in       = 1'b0;
         esc_in           = 1'b0;
         field_in         = FIELD_NAME;
         seen_type_in     = 1'b0;
         seen_assign_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_INDENT;
         indent_ff      <= '0;
         max_ff         <= '0;
         started_ff     <= 1'b0;
         esc_ff         <= 1'b0;
         field_ff       <= FIELD_NAME;
         seen_type_ff   <= 1'b0;
         seen_assign_ff <= 1'b0;
      end else if (en) begin
         phase_ff       <= phase_in;
         indent_ff      <= indent_in;
         max_ff         <= max_in;
         started_ff     <= started_in;
         esc_ff         <= esc_in;
         field_ff       <= field_in;
         seen_type_ff   <= seen_type_in;
         seen_assign_ff <= seen_assign_in;
      end
   end

endmodule

// ===== rtl/indented_text_line_lexer_top.sv =====
`timescale 1ns / 1ps
// Indented text line lexer: one text byte in, one result item out.
// Input channel req_*: req_doc_start clears all parse state before the byte,
// req_byte_in carries the raw byte. Result channel rsp_*: kind, target field,
// decoded character, line level, bare line and trailing escape flags, and
// the error code. Every accepted byte gives exactly one result item,
// in order.
// An accepted byte is loaded into the input register; its result is then
// loaded into the result register when the core advances, which raises
// rsp_valid, and the item leaves when rsp_ready is high.
// Throughput: one byte per cycle while rsp_ready stays high; the lexer state
// registers close a loop through the core logic, so each byte is folded in
// as it leaves the input register.
// Reset (synchronous, active high) empties both registers and returns the
// lexer to the start of a document.
// When the receiver holds rsp_ready low, the result register holds its item,
// the input register keeps one more byte, and req_ready drops once both
// are full.
`include "indented_text_line_lexer_top_defines.svh"

module indented_text_line_lexer_top import itll_pkg::*; #(
   parameter int MAX_LEVEL = LEVEL_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_doc_start,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [1:0] rsp_target_field,
   output logic [7:0] rsp_character,
   output logic [7:0] rsp_line_level,
   output logic       rsp_bare_line,
   output logic       rsp_append_nul,
   output logic [1:0] rsp_error_code
);

   logic         in_valid_ff, in_valid_in;
   logic         in_doc_ff;
   logic [7:0]   in_byte_ff;
   logic         out_valid_ff, out_valid_in;
   itll_rsp_type out_ff;
   itll_rsp_type core_rsp;
   logic         advance;
   logic         req_take;

   itll_core #(
      .MAX_LEVEL (MAX_LEVEL)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .doc_start (in_doc_ff),
      .byte_in   (in_byte_ff),
      .rsp       (core_rsp)
   );

   always_comb begin
      advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;
      req_take  = req_valid && req_ready;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_doc_ff  <= req_doc_start;
         in_byte_ff <= req_byte_in;
      end
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_target_field = out_ff.target_field;
   assign rsp_character    = out_ff.character;
   assign rsp_line_level   = out_ff.line_level;
   assign rsp_bare_line    = out_ff.bare_line;
   assign rsp_append_nul   = out_ff.append_nul;
   assign rsp_error_code   = out_ff.error_code;

   `ITLL_ASSERT_IMPL(a_stall_has_item, clock, reset, !req_ready,
                     in_valid_ff && out_valid_ff)
   `ITLL_ASSERT_IMPL(a_none_is_clear, clock, reset, rsp_valid && rsp_kind == KIND_NONE,
                     rsp_target_field == FIELD_NAME && rsp_character == 8'd0 &&
                     rsp_line_level == 8'd0 && rsp_error_code == ERR_LEVEL_JUMP)
   `ITLL_ASSERT_IMPL(a_flags_only_eol, clock, reset, rsp_valid && rsp_kind != KIND_EOL,
                     !rsp_bare_line && !rsp_append_nul)
   `ITLL_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff)

endmodule

// ===== tb/indented_text_line_lexer_checker.sv =====
`timescale 1ns / 1ps

module indented_text_line_lexer_checker import itll_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_doc_start,
   input  logic [7:0] req_byte_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [1:0] rsp_target_field,
   input  logic [7:0] rsp_character,
   input  logic [7:0] rsp_line_level,
   input  logic       rsp_bare_line,
   input  logic       rsp_append_nul,
   input  logic [1:0] rsp_error_code,
   output int         fail_count,
   output int         pending,
   output int         bytes_taken,
   output int         tokens_checked,
   output int         line_ends,
   output int         lex_errors
);

   typedef enum logic [1:0] {
      LEX_INDENT,
      LEX_CONTENT,
      LEX_ERROR
   } lex_phase_type;

   lex_phase_type  lex_phase;
   logic [7:0]     tab_count;
   logic [8:0]     level_cap;
   logic           line_open;
   logic           esc_pending;
   itll_field_type cur_field;
   logic           got_caret;
   logic           got_equals;

   itll_rsp_type due_tokens[$];

   assign pending = due_tokens.size();

   function void clear_line();
      lex_phase   = LEX_INDENT;
      tab_count   = '0;
      line_open   = 1'b0;
      esc_pending = 1'b0;
      cur_field   = FIELD_NAME;
      got_caret   = 1'b0;
      got_equals  = 1'b0;
   endfunction

   function itll_rsp_type lex_fail(itll_err_type code);
      itll_rsp_type r;
      r = '0;
      lex_phase = LEX_ERROR;
      r.kind = KIND_ERR;
      r.line_level = tab_count;
      r.error_code = code;
      return r;
   endfunction

   function itll_rsp_type line_end();
      itll_rsp_type r;
      r = '0;
      r.kind = KIND_EOL;
      r.target_field = cur_field;
      r.line_level = tab_count;
      r.bare_line = !got_caret && !got_equals;
      r.append_nul = esc_pending;
      clear_line();
      return r;
   endfunction

   function itll_rsp_type lex_byte(logic ds, logic [7:0] b);
      itll_rsp_type r;
      r = '0;
      if (ds) begin
         clear_line();
         level_cap = '0;
      end
      if (lex_phase != LEX_INDENT && lex_phase != LEX_CONTENT) return r;
      if (lex_phase == LEX_INDENT) begin
         if (b == CH_NEWLINE && !line_open) return r;
         if (b == CH_TAB) begin
            line_open = 1'b1;
            if (tab_count >= LEVEL_DEFAULT) return lex_fail(ERR_LEVEL_JUMP);
            tab_count = tab_count + 8'd1;
            return r;
         end
         line_open = 1'b1;
         if ({1'b0, tab_count} > level_cap) return lex_fail(ERR_LEVEL_JUMP);
         level_cap = {1'b0, tab_count} + 9'd1;
         if (b == CH_NEWLINE) return line_end();
         if (b == CH_SPACE) return lex_fail(ERR_LEADING_SPACE);
         lex_phase = LEX_CONTENT;
      end else if (b == CH_NEWLINE) begin
         return line_end();
      end
      if (esc_pending) begin
         esc_pending = 1'b0;
         r.kind = KIND_CHAR;
         r.target_field = cur_field;
         r.line_level = tab_count;
         r.character = (b == CH_PIPE) ? CH_NEWLINE : (b == CH_GREATER) ? CH_TAB : b;
         return r;
      end
      unique case (b)
         CH_QUOTE: esc_pending = 1'b1;
         CH_CARET: begin
            if (got_caret || got_equals) return lex_fail(ERR_TYPE_SEP);
            cur_field = FIELD_TYPE;
            got_caret = 1'b1;
         end
         CH_EQUALS: begin
            if (got_equals) return lex_fail(ERR_REPEAT_ASSIGN);
            cur_field = FIELD_VALUE;
            got_equals = 1'b1;
         end
         default: begin
            r.kind = KIND_CHAR;
            r.target_field = cur_field;
            r.character = b;
            r.line_level = tab_count;
         end
      endcase
      return r;
   endfunction

   task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 40) $display("MISMATCH at token %0d: %s", tokens_checked, msg);
   endtask

   always @(posedge clock) begin
      itll_rsp_type want;
      if (reset) begin
         due_tokens.delete();
         clear_line();
         level_cap = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected token, kind %0d", rsp_kind));
            end else begin
               want = due_tokens.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
               if (rsp_target_field !== want.target_field)
                  report_mismatch($sformatf("target_field %0d, want %0d",
                                            rsp_target_field, want.target_field));
               if (rsp_character !== want.character)
                  report_mismatch($sformatf("character %0d, want %0d",
                                            rsp_character, want.character));
               if (rsp_line_level !== want.line_level)
                  report_mismatch($sformatf("line_level %0d, want %0d",
                                            rsp_line_level, want.line_level));
               if (rsp_bare_line !== want.bare_line)
                  report_mismatch($sformatf("bare_line %0d, want %0d",
                                            rsp_bare_line, want.bare_line));
               if (rsp_append_nul !== want.append_nul)
                  report_mismatch($sformatf("append_nul %0d, want %0d",
                                            rsp_append_nul, want.append_nul));
               if (rsp_error_code !== want.error_code)
                  report_mismatch($sformatf("error_code %0d, want %0d",
                                            rsp_error_code, want.error_code));
               if (want.kind == KIND_EOL) line_ends++;
               if (want.kind == KIND_ERR) lex_errors++;
               tokens_checked++;
            end
         end
         if (req_valid && req_ready) begin
            due_tokens.insert(due_tokens.size(), lex_byte(req_doc_start, req_byte_in));
            bytes_taken++;
         end
      end
   end

endmodule

// ===== tb/indented_text_line_lexer_top_test.sv =====
`timescale 1ns / 1ps

module indented_text_line_lexer_top_test;
   import itll_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_BYTES = 400;

   typedef enum {
      FLAW_NONE,
      FLAW_JUMP,
      FLAW_SPACE,
      FLAW_CARET,
      FLAW_EQUALS,
      FLAW_DEEP
   } line_flaw_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_doc_start;
   logic [7:0] req_byte_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [1:0] rsp_target_field;
   logic [7:0] rsp_character;
   logic [7:0] rsp_line_level;
   logic       rsp_bare_line;
   logic       rsp_append_nul;
   logic [1:0] rsp_error_code;

   int fail_count;
   int pending;
   int bytes_taken;
   int tokens_checked;
   int line_ends;
   int lex_errors;

   int sender_idle_pct;
   int receiver_stall_pct;
   int quiet_cycles;
   int sent;
   int gen_cap;
   bit dead = 1'b1;
   bit deep_done;
   logic [8:0] burst[$];

   int idle_plan[4]  = '{0, 81, 0, 31};
   int stall_plan[4] = '{0, 0, 81, 31};

   indented_text_line_lexer_top dut (.*);

   indented_text_line_lexer_checker token_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("** indented_text_line_lexer_top: FAILED **");
            $finish;
         end
      end
   end

   function void put(logic ds, logic [7:0] b);
      burst.insert(burst.size(), {ds, b});
   endfunction

   function void put_text(int n, bit lead);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 15) begin
            put(1'b0, CH_QUOTE);
            case ($urandom_range(3))
               0: c = CH_PIPE;
               1: c = CH_GREATER;
               default: c = 8'($urandom_range(255));
            endcase
            if (c == CH_NEWLINE) c = CH_QUOTE;
         end else begin
            c = 8'($urandom_range(255));
            if (c == CH_NEWLINE || c == CH_QUOTE || c == CH_CARET || c == CH_EQUALS)
               c = 8'h41 + 8'($urandom_range(25));
            if (lead && i == 0 && (c == CH_TAB || c == CH_SPACE)) c = 8'h61;
         end
         put(1'b0, c);
      end
   endfunction

   function void build_line();
      int            lvl;
      int            roll;
      bit            fresh;
      bit            with_caret;
      bit            with_equals;
      line_flaw_type flaw;
      burst.delete();
      fresh = dead || ($urandom_range(99) < 10);
      if (fresh) begin
         gen_cap = 0;
         dead = 1'b0;
      end
      roll = $urandom_range(99);
      flaw = FLAW_NONE;
      if (roll < 4) begin
         repeat ($urandom_range(12, 3))
            put($urandom_range(15) == 0,
                ($urandom_range(4) == 0) ? CH_NEWLINE : 8'($urandom_range(255)));
         dead = 1'b1;
      end else if (roll < 9) begin
         put(1'b0, CH_NEWLINE);
      end else begin
         if (roll >= 93) flaw = line_flaw_type'($urandom_range(FLAW_DEEP, FLAW_JUMP));
         if (!deep_done && sent > 200) flaw = FLAW_DEEP;
         lvl = (gen_cap == 0 || $urandom_range(99) < 40) ? gen_cap : $urandom_range(gen_cap);
         if (lvl > 20) lvl = $urandom_range(20);
         if (flaw == FLAW_JUMP) lvl = gen_cap + 1 + $urandom_range(2);
         if (flaw == FLAW_DEEP) begin
            lvl = deep_done ? $urandom_range(256, 100) : 256;
            deep_done = 1'b1;
         end
         repeat (lvl) put(1'b0, CH_TAB);
         if (flaw == FLAW_SPACE) put(1'b0, CH_SPACE);
         put_text($urandom_range(6), flaw != FLAW_SPACE);
         with_caret = ($urandom_range(99) < 35);
         with_equals = ($urandom_range(99) < 45);
         if (with_caret) begin
            put(1'b0, CH_CARET);
            put_text($urandom_range(4), 1'b0);
         end
         if (with_equals) begin
            put(1'b0, CH_EQUALS);
            put_text($urandom_range(6), 1'b0);
         end
         if (flaw == FLAW_CARET) begin
            if (!with_caret && !with_equals) put(1'b0, CH_EQUALS);
            put(1'b0, CH_CARET);
            put_text(2, 1'b0);
         end
         if (flaw == FLAW_EQUALS) begin
            if (!with_equals) put(1'b0, CH_EQUALS);
            put(1'b0, CH_EQUALS);
         end
         if ($urandom_range(99) < 10) put(1'b0, CH_QUOTE);
         put(1'b0, CH_NEWLINE);
         if (flaw != FLAW_NONE) dead = 1'b1;
         else if (burst.size() > 1) gen_cap = lvl + 1;
      end
      burst[0][8] = burst[0][8] | fresh;
   endfunction

   task automatic send_byte(logic ds, logic [7:0] b);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_doc_start <= ds;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_byte(burst[i][8], burst[i][7:0]);
   endtask

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_doc_start = 1'b0;
      req_byte_in = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      burst.delete();
      put(1'b1, CH_NEWLINE);
      put(1'b0, "x");
      put(1'b0, CH_CARET);
      put(1'b0, "y");
      put(1'b0, CH_EQUALS);
      put(1'b0, 8'hFF);
      put(1'b0, CH_NEWLINE);
      put(1'b0, CH_TAB);
      put(1'b0, CH_NEWLINE);
      put(1'b0, CH_TAB);
      put(1'b0, CH_TAB);
      put(1'b0, 8'h00);
      put(1'b0, CH_QUOTE);
      put(1'b0, CH_PIPE);
      put(1'b0, CH_QUOTE);
      put(1'b0, CH_GREATER);
      put(1'b0, CH_QUOTE);
      put(1'b0, CH_NEWLINE);
      put(1'b1, CH_TAB);
      put(1'b0, CH_NEWLINE);
      put(1'b1, CH_SPACE);
      put(1'b0, "z");
      put(1'b1, CH_EQUALS);
      put(1'b0, CH_EQUALS);
      put(1'b1, CH_CARET);
      put(1'b0, CH_CARET);
      send_burst();

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_plan[p];
         receiver_stall_pct = stall_plan[p];
         target = sent + PHASE_BYTES;
         while (sent < target) begin
            build_line();
            send_burst();
         end
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
      end

      repeat (8) @(posedge clock);
      $display("Lexed %0d bytes into %0d checked tokens: %0d line ends, %0d syntax errors.",
               bytes_taken, tokens_checked, line_ends, lex_errors);
      $display("Pacing ran free, with a sparse sender, a stalling receiver, then both.");
      if (fail_count == 0)
         $display("** indented_text_line_lexer_top: PASSED **");
      else
         $display("** indented_text_line_lexer_top: FAILED **");
      $finish;
   end

endmodule
